// ===== hdl/nlt_pkg.sv =====
// Package for the node location table: sizes, codes and the request type.
// No dependencies; used by every module of the block.
package nlt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_SWEEP  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_STALE = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam int REQ_W = 210;
    localparam int RES_W = 199;

    typedef struct packed {
        logic [31:0] now;
        logic [31:0] heading;
        logic [31:0] velocity;
        logic [7:0]  seq_num;
        logic [7:0]  hop_count;
        logic [15:0] via_node;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
        logic [15:0] node_id;
        logic [1:0]  opcode;
    } req_t;

    typedef struct packed {
        logic [4:0]  removed_count;
        logic [15:0] out_via;
        logic [31:0] out_stamp;
        logic [31:0] out_heading;
        logic [31:0] out_speed;
        logic [7:0]  out_seq;
        logic [7:0]  out_hops;
        logic [31:0] out_y;
        logic [31:0] out_x;
        logic [1:0]  status;
    } res_t;

endpackage

// ===== hdl/nlt_front.sv =====
// Front end: takes request items into a two-entry queue.
// Depends on nlt_pkg.
module nlt_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  nlt_pkg::req_t        in_req,
    output logic                 q_valid,
    input  logic                 q_pop,
    output nlt_pkg::req_t        q_req
);
    nlt_pkg::req_t mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_req;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

// ===== hdl/nlt_back.sv =====
// Back end: scans the table one slot per cycle and executes one request.
// Depends on nlt_pkg.
module nlt_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [31:0]      age_limit,
    input  logic             q_valid,
    output logic             q_pop,
    input  nlt_pkg::req_t    q_req,
    output logic             res_valid,
    input  logic             res_ready,
    output nlt_pkg::res_t    res
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC, S_OUT} state_t;

    typedef struct packed {
        logic [15:0] key;
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] via;
        logic [7:0]  hops;
        logic [7:0]  seq;
        logic [31:0] speed;
        logic [31:0] heading;
        logic [31:0] stamp;
    } slot_t;

    slot_t                        mem [nlt_pkg::ENTRIES];
    logic [nlt_pkg::ENTRIES-1:0]  valid_reg;
    state_t                       state_reg;
    nlt_pkg::req_t                req_reg;
    logic [nlt_pkg::CNT_W-1:0]    idx_reg;
    logic                         hit_reg, free_reg;
    logic [nlt_pkg::IDX_W-1:0]    hit_idx_reg, free_idx_reg;
    logic [4:0]                   cnt_reg;
    nlt_pkg::res_t                res_reg;
    nlt_pkg::res_t                res_next;
    slot_t                        rd_reg;
    logic                         rd_valid_reg;
    logic [nlt_pkg::IDX_W-1:0]    rd_idx_reg;
    slot_t                        hit_slot_reg;
    slot_t                        wr_slot;
    logic [32:0]                  age_diff;
    logic                         aged;
    logic                         stale;

    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;

    assign age_diff = {1'b0, req_reg.now} - {1'b0, rd_reg.stamp};
    assign aged     = !age_diff[32] && (age_diff[31:0] > age_limit);

    // same position and not newer or not shorter: update refused
    assign stale = hit_slot_reg.x == req_reg.pos_x && hit_slot_reg.y == req_reg.pos_y
                   && (req_reg.seq_num <= hit_slot_reg.seq
                       || hit_slot_reg.hops <= req_reg.hop_count);

    always_comb begin
        wr_slot.key     = req_reg.node_id;
        wr_slot.x       = req_reg.pos_x;
        wr_slot.y       = req_reg.pos_y;
        wr_slot.via     = req_reg.via_node;
        wr_slot.hops    = req_reg.hop_count;
        wr_slot.seq     = req_reg.seq_num;
        wr_slot.speed   = req_reg.velocity;
        wr_slot.heading = req_reg.heading;
        wr_slot.stamp   = req_reg.now;
    end

    always_comb begin
        res_next        = '0;
        res_next.status = nlt_pkg::ST_OK;
        case (req_reg.opcode)
            nlt_pkg::OP_INSERT: begin
                if (hit_reg) begin
                    if (stale) res_next.status = nlt_pkg::ST_STALE;
                end else if (!free_reg) begin
                    res_next.status = nlt_pkg::ST_FULL;
                end
            end
            nlt_pkg::OP_LOOKUP: begin
                if (hit_reg) begin
                    res_next.out_x       = hit_slot_reg.x;
                    res_next.out_y       = hit_slot_reg.y;
                    res_next.out_hops    = hit_slot_reg.hops;
                    res_next.out_seq     = hit_slot_reg.seq;
                    res_next.out_speed   = hit_slot_reg.speed;
                    res_next.out_heading = hit_slot_reg.heading;
                    res_next.out_stamp   = hit_slot_reg.stamp;
                    res_next.out_via     = hit_slot_reg.via;
                end else begin
                    res_next.status = nlt_pkg::ST_MISS;
                end
            end
            nlt_pkg::OP_REMOVE: begin
                if (hit_reg) begin
                    res_next.removed_count = 5'd1;
                end else begin
                    res_next.status = nlt_pkg::ST_MISS;
                end
            end
            default: begin
                res_next.removed_count = cnt_reg;
            end
        endcase
    end

    // slot memory: registered read, taken in the cycle before the compare
    always_ff @(posedge aclk) begin
        if (state_reg == S_SCAN && idx_reg < nlt_pkg::CNT_W'(nlt_pkg::ENTRIES)) begin
            rd_reg <= mem[idx_reg[nlt_pkg::IDX_W-1:0]];
        end
        if (state_reg == S_EXEC && req_reg.opcode == nlt_pkg::OP_INSERT) begin
            if (hit_reg) begin
                if (!stale) begin
                    mem[hit_idx_reg] <= wr_slot;
                end
            end else if (free_reg) begin
                mem[free_idx_reg] <= wr_slot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        req_reg      <= q_req;
                        idx_reg      <= '0;
                        hit_reg      <= 1'b0;
                        free_reg     <= 1'b0;
                        cnt_reg      <= '0;
                        rd_valid_reg <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    rd_valid_reg <= (idx_reg < nlt_pkg::CNT_W'(nlt_pkg::ENTRIES));
                    rd_idx_reg   <= idx_reg[nlt_pkg::IDX_W-1:0];
                    idx_reg      <= idx_reg + 1'b1;
                    if (rd_valid_reg) begin
                        if (valid_reg[rd_idx_reg]) begin
                            if (req_reg.opcode == nlt_pkg::OP_SWEEP) begin
                                if (aged) begin
                                    valid_reg[rd_idx_reg] <= 1'b0;
                                    if (cnt_reg != 5'd31) cnt_reg <= cnt_reg + 5'd1;
                                end
                            end else if (!hit_reg && rd_reg.key == req_reg.node_id) begin
                                hit_reg      <= 1'b1;
                                hit_idx_reg  <= rd_idx_reg;
                                hit_slot_reg <= rd_reg;
                            end
                        end else if (!free_reg) begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= rd_idx_reg;
                        end
                    end
                    if (idx_reg == nlt_pkg::CNT_W'(nlt_pkg::ENTRIES)) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    res_reg <= res_next;
                    case (req_reg.opcode)
                        nlt_pkg::OP_INSERT: begin
                            if (!hit_reg && free_reg) begin
                                valid_reg[free_idx_reg] <= 1'b1;
                            end
                        end
                        nlt_pkg::OP_REMOVE: begin
                            if (hit_reg) begin
                                valid_reg[hit_idx_reg] <= 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (res_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/node_location_table_top.sv =====
// Top level of the node location table: APB register, request queue and
// table engine. Depends on nlt_pkg, nlt_front and nlt_back.
//
// A keyed table of ENTRIES (16) node records. Each request item is one of
// insert/update, lookup, remove or age sweep, and yields exactly one result
// item. The engine walks the table one slot per cycle through a registered
// slot memory: it takes the item from the queue, scans every slot, executes
// the request and presents the result, and takes no new item until that
// result is taken. That slot scan sets the rate, and a stalled result stalls
// the engine. A two-entry queue in front takes new items while the engine
// works, and the result register holds its item until it is taken. The age
// limit register (index 0, byte address 0, reset 1500) must be written only
// while idle.
module node_location_table_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          s_tvalid,
    output logic          s_tready,
    // opcode, node_id, pos_x, pos_y, via_node, hop_count, seq_num, velocity,
    // heading, now (from bit 0 up), zero padded to 216 bits
    input  logic [215:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // status, out_x, out_y, out_hops, out_seq, out_speed, out_heading,
    // out_stamp, out_via, removed_count (from bit 0 up), zero padded
    output logic [199:0]  m_tdata
);
    logic [31:0]    age_limit_reg;
    logic           q_valid, q_pop;
    nlt_pkg::req_t  q_req;
    nlt_pkg::res_t  res;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? age_limit_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_limit_reg <= 32'd1500;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            age_limit_reg <= pwdata;
        end
    end

    nlt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (s_tdata[nlt_pkg::REQ_W-1:0]),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req)
    );

    nlt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .age_limit (age_limit_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_req     (q_req),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {1'b0, res};
endmodule
